// File: design/codeword_to_rgb_block_decoder_unit_macros.svh
// assertion macros for the codeword to rgb block decoder checks
`ifndef CODEWORD_TO_RGB_BLOCK_DECODER_UNIT_MACROS_SVH
`define CODEWORD_TO_RGB_BLOCK_DECODER_UNIT_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define CTRBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ctrbd check failed");

// next-cycle implication, masked while reset is asserted
`define CTRBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ctrbd check failed");

// next-cycle implication that stays live during reset
`define CTRBD_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("ctrbd reset check failed");

`endif

// File: design/ctrbd_pkg.sv
// types, constants and helper functions of the codeword to rgb block decoder
package ctrbd_pkg;

    // fixed point format
    localparam int FRAC_BITS = 14;
    localparam int ONE_Q     = 1 << FRAC_BITS;
    localparam longint ONE_QL = longint'(1) << FRAC_BITS;

    // stream word widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;
    localparam int CW_W      = 32;
    localparam int BLK_W     = 11;
    localparam int COORD_W   = 12;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_REGS  = 4;

    // codeword field widths
    localparam int A_W   = 9;
    localparam int DIG_W = 5;
    localparam int IDX_W = 4;

    // average: a*ONE_Q/63 = a*A_INT + round(a*A_REM/63), rest by reciprocal
    localparam int A_DEN_HALF = 63;
    localparam int A_INT      = ONE_Q / A_DEN_HALF;
    localparam int A_REM      = ONE_Q % A_DEN_HALF;
    localparam int A_DEN      = 2 * A_DEN_HALF;
    localparam int A_NUM_W    = 13;
    localparam int RECIP_SH   = 20;
    localparam int RECIP_W    = 14;
    localparam int A_RECIP    = ((1 << RECIP_SH) + A_DEN - 1) / A_DEN;
    localparam int AQ_W       = 6;
    localparam int AVG_W      = 18;

    // detail coefficients
    localparam int DET_W   = 14;
    localparam int DET_LIM = (3 * ONE_Q + 5) / 10;
    localparam int DET_N   = 1 << DIG_W;

    // chroma and color coefficients
    localparam int CHR_W  = 16;
    localparam int COEF_W = 16;
    localparam int PROD_W = 32;
    localparam longint KR_L  = (longint'(1402) * ONE_QL * 2 + 1000) / 2000;
    localparam longint KGB_L = (longint'(344136) * ONE_QL * 2 + 1000000) / 2000000;
    localparam longint KGR_L = (longint'(714136) * ONE_QL * 2 + 1000000) / 2000000;
    localparam longint KB_L  = (longint'(1772) * ONE_QL * 2 + 1000) / 2000;

    // luma and color sums
    localparam int LUMA_W = 19;
    localparam int SUM_W  = 34;
    localparam int SCL_W  = SUM_W + 8;
    localparam int BYTE_W = 8;

    typedef logic signed [DET_W-1:0]   det_t;
    typedef logic signed [CHR_W-1:0]   chr_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [LUMA_W-1:0]  luma_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [AVG_W-1:0]          avg_t;
    typedef logic [BLK_W-1:0]          blk_t;
    typedef logic [COORD_W-1:0]        coord_t;
    typedef logic [BYTE_W-1:0]         byte_t;
    typedef det_t                      det_tab_t [DET_N];

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHROMA_W0 = 2'd0,
        REG_CHROMA_W1 = 2'd1,
        REG_CHROMA_W2 = 2'd2,
        REG_CHROMA_W3 = 2'd3
    } cfg_reg_t;

    localparam coef_t KR  = COEF_W'(KR_L);
    localparam coef_t KGB = COEF_W'(KGB_L);
    localparam coef_t KGR = COEF_W'(KGR_L);
    localparam coef_t KB  = COEF_W'(KB_L);

    // 5-bit signed detail code -> round(v/100) in Q.F, clamped to +-0.3
    function automatic det_tab_t build_detail();
        det_tab_t tab;
        int v;
        int m;
        int q;
        for (int i = 0; i < DET_N; i++) begin
            v = (i < DET_N / 2) ? i : i - DET_N;
            m = (v < 0) ? -v : v;
            q = (m * ONE_Q * 2 + 100) / 200;
            if (v < 0) q = -q;
            if (q > DET_LIM) q = DET_LIM;
            if (q < -DET_LIM) q = -DET_LIM;
            tab[i] = DET_W'(q);
        end
        return tab;
    endfunction

    localparam det_tab_t DETAIL_TAB = build_detail();

    // Q.2F color sum -> byte: times 255, truncate, saturate
    function automatic byte_t to_byte(input sum_t s);
        logic signed [SCL_W-1:0] se;
        logic signed [SCL_W-1:0] v;
        byte_t res;
        se = SCL_W'(s);
        v  = (se <<< 8) - se;
        if (s < 0) begin
            res = '0;
        end else if (|v[SCL_W-1:2*FRAC_BITS+BYTE_W]) begin
            res = '1;
        end else begin
            res = v[2*FRAC_BITS +: BYTE_W];
        end
        return res;
    endfunction

endpackage

// File: design/codeword_to_rgb_block_decoder_unit.sv
// top level of the codeword to rgb block decoder
//
// usage:
// - s_ channel: one word per 2x2 block, s_tdata = codeword, block column, block row
// - m_ channel: four pixel words per block in order top-left, top-right,
//   bottom-left, bottom-right; m_tlast marks the bottom-right pixel
// - cfg channel: loads the four 64-bit chroma table registers, one write per
//   cycle, cfg_ready always high; write only while the block is idle
// - path: an accepted word passes s1, s2, s3 and the hold stage; the first pixel
//   of its block then passes p1 and p2 to m_tvalid, the other three in order
// - throughput: one pixel per cycle while m_tready stays high, so one block word
//   per four pixels; the pixel stream leaving the holding stage sets that rate
// - up to four words are taken back to back until the stages fill up
// - reset (aresetn low at a clock edge) empties every stage and clears the
//   chroma table to zero
// - when m_tready is low the output word holds and the stages behind it fill
//   and stop in turn; s_tready drops once the front stage is full, no word lost
//
// stages: s1 decode and table lookups, s2 multiplies, s3 luma and chroma terms,
// hold stage sends out four pixels, p1 color sums, p2 saturation and output
module codeword_to_rgb_block_decoder_unit
    import ctrbd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // packed_word[31:0], block_col[42:32], block_row[53:43], zeros[55:54]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // pixel stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_x[11:0], pixel_y[23:12], red[31:24], green[39:32], blue[47:40]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // last_of_block
    output logic                  m_tlast,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    // chroma table registers
    logic [CFG_W-1:0] chroma_reg [CFG_REGS];

    // stage 1
    logic                s1_valid_reg;
    avg_t                s1_a_int_reg;
    logic [A_NUM_W-1:0]  s1_a_num_reg;
    det_t                s1_b_reg, s1_c_reg, s1_d_reg;
    chr_t                s1_pb_reg, s1_pr_reg;
    blk_t                s1_col_reg, s1_row_reg;

    // stage 2
    logic                s2_valid_reg;
    avg_t                s2_a_reg;
    det_t                s2_b_reg, s2_c_reg, s2_d_reg;
    prod_t               s2_red_prod_reg, s2_gpb_prod_reg, s2_gpr_prod_reg, s2_blue_prod_reg;
    blk_t                s2_col_reg, s2_row_reg;

    // stage 3
    logic                s3_valid_reg;
    luma_t               s3_luma_reg [4];
    prod_t               s3_red_chr_reg, s3_green_chr_reg, s3_blue_chr_reg;
    blk_t                s3_col_reg, s3_row_reg;

    // holding stage, sends four pixels
    logic                hold_valid_reg;
    logic [1:0]          hold_cnt_reg;
    luma_t               hold_luma_reg [4];
    prod_t               hold_red_chr_reg, hold_green_chr_reg, hold_blue_chr_reg;
    blk_t                hold_col_reg, hold_row_reg;

    // pixel stage 1: color sums
    logic                p1_valid_reg;
    sum_t                p1_red_reg, p1_green_reg, p1_blue_reg;
    coord_t              p1_x_reg, p1_y_reg;
    logic                p1_last_reg;

    // pixel stage 2: output word
    logic                out_valid_reg;
    byte_t               out_red_reg, out_green_reg, out_blue_reg;
    coord_t              out_x_reg, out_y_reg;
    logic                out_last_reg;

    // flow control, back to front
    logic out_ready, p1_ready, hold_ready, hold_emit, s3_ready, s2_ready, s1_ready;

    assign out_ready  = !out_valid_reg || m_tready;
    assign p1_ready   = !p1_valid_reg || out_ready;
    assign hold_emit  = hold_valid_reg && p1_ready;
    assign hold_ready = !hold_valid_reg || (p1_ready && (hold_cnt_reg == 2'd3));
    assign s3_ready   = !s3_valid_reg || hold_ready;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;

    assign s_tready  = s1_ready;
    assign cfg_ready = 1'b1;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CFG_REGS; i++) chroma_reg[i] <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CHROMA_W0: chroma_reg[0] <= cfg_data;
                REG_CHROMA_W1: chroma_reg[1] <= cfg_data;
                REG_CHROMA_W2: chroma_reg[2] <= cfg_data;
                REG_CHROMA_W3: chroma_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // codeword fields
    logic [CW_W-1:0]   cw;
    logic [A_W-1:0]    cw_a;
    logic [IDX_W-1:0]  pb_idx, pr_idx;
    avg_t              s1_a_int_next;
    logic [A_NUM_W-1:0] s1_a_num_next;

    assign cw     = s_tdata[CW_W-1:0];
    assign cw_a   = cw[31:23];
    assign pb_idx = cw[7:4];
    assign pr_idx = cw[3:0];

    // a*16384/63 split into a whole part and a remainder numerator
    assign s1_a_int_next = AVG_W'(cw_a) * AVG_W'(A_INT);
    assign s1_a_num_next = A_NUM_W'(cw_a) * A_NUM_W'(2 * A_REM) + A_NUM_W'(A_DEN_HALF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && s_tvalid) begin
            s1_a_int_reg <= s1_a_int_next;
            s1_a_num_reg <= s1_a_num_next;
            s1_b_reg     <= DETAIL_TAB[cw[22:18]];
            s1_c_reg     <= DETAIL_TAB[cw[17:13]];
            s1_d_reg     <= DETAIL_TAB[cw[12:8]];
            s1_pb_reg    <= chroma_reg[pb_idx[3:2]][{pb_idx[1:0], 4'd0} +: CHR_W];
            s1_pr_reg    <= chroma_reg[pr_idx[3:2]][{pr_idx[1:0], 4'd0} +: CHR_W];
            s1_col_reg   <= s_tdata[CW_W +: BLK_W];
            s1_row_reg   <= s_tdata[CW_W+BLK_W +: BLK_W];
        end
    end

    // stage 2: reciprocal multiply for the rounded remainder, chroma products
    logic [A_NUM_W+RECIP_W-1:0] a_prod;
    logic [AQ_W-1:0]            a_frac;

    assign a_prod = (A_NUM_W+RECIP_W)'(s1_a_num_reg) * (A_NUM_W+RECIP_W)'(A_RECIP);
    assign a_frac = a_prod[RECIP_SH +: AQ_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_a_reg         <= s1_a_int_reg + AVG_W'(a_frac);
            s2_b_reg         <= s1_b_reg;
            s2_c_reg         <= s1_c_reg;
            s2_d_reg         <= s1_d_reg;
            s2_red_prod_reg  <= KR * s1_pr_reg;
            s2_gpb_prod_reg  <= KGB * s1_pb_reg;
            s2_gpr_prod_reg  <= KGR * s1_pr_reg;
            s2_blue_prod_reg <= KB * s1_pb_reg;
            s2_col_reg       <= s1_col_reg;
            s2_row_reg       <= s1_row_reg;
        end
    end

    // stage 3: inverse 2x2 transform, green chroma term
    luma_t y_a, y_b, y_c, y_d;

    assign y_a = $signed({1'b0, s2_a_reg});
    assign y_b = LUMA_W'(s2_b_reg);
    assign y_c = LUMA_W'(s2_c_reg);
    assign y_d = LUMA_W'(s2_d_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_ready && s2_valid_reg) begin
            s3_luma_reg[0]   <= y_a - y_b - y_c + y_d;
            s3_luma_reg[1]   <= y_a - y_b + y_c - y_d;
            s3_luma_reg[2]   <= y_a + y_b - y_c - y_d;
            s3_luma_reg[3]   <= y_a + y_b + y_c + y_d;
            s3_red_chr_reg   <= s2_red_prod_reg;
            s3_green_chr_reg <= -s2_gpb_prod_reg - s2_gpr_prod_reg;
            s3_blue_chr_reg  <= s2_blue_prod_reg;
            s3_col_reg       <= s2_col_reg;
            s3_row_reg       <= s2_row_reg;
        end
    end

    // holding stage: counts out the four pixels of one block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            hold_cnt_reg   <= '0;
        end else if (hold_ready) begin
            hold_valid_reg <= s3_valid_reg;
            hold_cnt_reg   <= '0;
        end else if (hold_emit) begin
            hold_cnt_reg   <= hold_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_ready && s3_valid_reg) begin
            for (int k = 0; k < 4; k++) hold_luma_reg[k] <= s3_luma_reg[k];
            hold_red_chr_reg   <= s3_red_chr_reg;
            hold_green_chr_reg <= s3_green_chr_reg;
            hold_blue_chr_reg  <= s3_blue_chr_reg;
            hold_col_reg       <= s3_col_reg;
            hold_row_reg       <= s3_row_reg;
        end
    end

    // pixel stage 1: luma in Q.2F plus chroma terms
    luma_t y_sel;
    sum_t  y_q;

    assign y_sel = hold_luma_reg[hold_cnt_reg];
    assign y_q   = SUM_W'(y_sel) <<< FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_ready) begin
            p1_valid_reg <= hold_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_emit) begin
            p1_red_reg   <= y_q + SUM_W'(hold_red_chr_reg);
            p1_green_reg <= y_q + SUM_W'(hold_green_chr_reg);
            p1_blue_reg  <= y_q + SUM_W'(hold_blue_chr_reg);
            // pixel column bit 0 and row bit 0 follow the pixel order
            p1_x_reg     <= {hold_col_reg, hold_cnt_reg[0]};
            p1_y_reg     <= {hold_row_reg, hold_cnt_reg[1]};
            p1_last_reg  <= (hold_cnt_reg == 2'd3);
        end
    end

    // pixel stage 2: scale, truncate, saturate into the output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && p1_valid_reg) begin
            out_red_reg   <= to_byte(p1_red_reg);
            out_green_reg <= to_byte(p1_green_reg);
            out_blue_reg  <= to_byte(p1_blue_reg);
            out_x_reg     <= p1_x_reg;
            out_y_reg     <= p1_y_reg;
            out_last_reg  <= p1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_blue_reg, out_green_reg, out_red_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: design/ctrbd_checker.sv
// port checks of the codeword to rgb block decoder and their bind
`include "codeword_to_rgb_block_decoder_unit_macros.svh"

module ctrbd_checker
    import ctrbd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  m_tlast
);

    logic                 out_stall;
    logic                 out_take;
    // block row and column of the pixel word
    logic [2*BLK_W-1:0]   blk_pos;

    assign out_stall = m_tvalid && !m_tready;
    assign out_take  = m_tvalid && m_tready;
    assign blk_pos   = {m_tdata[23:13], m_tdata[11:1]};

    // a stalled pixel word holds
    `CTRBD_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // reset empties the output stage
    `CTRBD_ASSERT_ALWAYS(a_reset_empty, !aresetn, !m_tvalid)

    // last marks exactly the bottom-right pixel
    `CTRBD_ASSERT_NOW(a_last_pos, m_tvalid, m_tlast == (m_tdata[0] && m_tdata[12]))

    // pixels of one block leave back to back with the same block position
    `CTRBD_ASSERT_NEXT(a_block_burst, out_take && !m_tlast, m_tvalid && $stable(blk_pos))

endmodule

bind codeword_to_rgb_block_decoder_unit ctrbd_checker u_ctrbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
